/* src/twd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twd_pkg
// Shared types, constants and stage numbering for the tunable-white
// dimming to PWM compare pipeline.
// ----------------------------------------------------------------------------
package twd_pkg;

  // curve and scaling constants
  localparam int unsigned FULL_SCALE = 65280;
  localparam int unsigned FLOOR_PCT  = 1;
  localparam int unsigned TOP_PCT    = 100;

  localparam int DW        = 16;
  localparam int X_W       = 2 * DW;
  localparam int CFG_IDX_W = 8;

  // level below 1 << TAIL_W gets the tail scale level/256
  localparam int TAIL_W = 8;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_MIREDS       = 8'd0,
    CFG_MAX_MIREDS       = 8'd1,
    CFG_PWM_PERIOD_TICKS = 8'd2,
    CFG_ACTIVE_LOW       = 8'd3
  } cfg_idx_t;

  // curve numerator: floor * full + (top - floor) * v, divided by top
  localparam bit          CURVE_UP   = (TOP_PCT >= FLOOR_PCT);
  localparam int unsigned CURVE_K    = CURVE_UP ? (TOP_PCT - FLOOR_PCT)
                                                : (FLOOR_PCT - TOP_PCT);
  localparam longint unsigned CURVE_BASE = longint'(FLOOR_PCT) * longint'(FULL_SCALE);
  localparam longint unsigned CURVE_NUM_MAX =
    longint'(CURVE_UP ? TOP_PCT : FLOOR_PCT) * longint'(FULL_SCALE);
  localparam int NUM_W = $clog2(CURVE_NUM_MAX + 1);
  // reciprocal of top with NUM_W fraction bits: estimate is exact or one low
  localparam longint unsigned CURVE_RECIP = (64'd1 << NUM_W) / TOP_PCT;
  localparam int CRECIP_W = $clog2(CURVE_RECIP + 1);
  localparam int CPROD_W  = NUM_W + CRECIP_W;
  localparam int CREM_W   = $clog2(2 * TOP_PCT);
  localparam int TAILP_W  = NUM_W + TAIL_W;

  // reciprocal of full scale with X_W fraction bits
  localparam longint unsigned TICK_RECIP = (64'd1 << X_W) / FULL_SCALE;
  localparam int TRECIP_W = $clog2(TICK_RECIP + 1);
  localparam int TPROD_W  = X_W + TRECIP_W;
  localparam int TREM_W   = $clog2(2 * FULL_SCALE);

  // channels
  localparam int NCH     = 2;
  localparam int CH_COOL = 0;
  localparam int CH_WARM = 1;

  // stage numbering
  localparam int STG_CLAMP = 0;
  localparam int STG_MUL   = 1;
  localparam int STG_DIV0  = 2;
  localparam int STG_SPLIT = STG_DIV0 + DW;
  localparam int STG_CNUM  = STG_SPLIT + 1;
  localparam int STG_CMUL  = STG_CNUM + 1;
  localparam int STG_CREM  = STG_CMUL + 1;
  localparam int STG_CFIX  = STG_CREM + 1;
  localparam int STG_TAIL  = STG_CFIX + 1;
  localparam int STG_INV   = STG_TAIL + 1;
  localparam int STG_XMUL  = STG_INV + 1;
  localparam int STG_TMUL  = STG_XMUL + 1;
  localparam int STG_TREM  = STG_TMUL + 1;
  localparam int NPIPE     = STG_TREM + 1;

  // values that ride alongside the per-channel work
  typedef struct packed {
    logic [DW-1:0]     cool_share;
    logic [DW-1:0]     warm_share;
    logic              tail_en;
    logic [TAIL_W-1:0] tail_mul;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] cool_share;
    logic [DW-1:0] warm_share;
    logic [DW-1:0] cool_compare;
    logic [DW-1:0] warm_compare;
  } res_t;

endpackage

/* src/tunable_white_dim_to_pwm_compare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tunable_white_dim_to_pwm_compare
// Colour temperature and fine level in, cool/warm shares and PWM compare
// values out, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// in_      | in        | in_valid / in_stall  | in_mireds, in_level
// out_     | out       | out_valid / out_stall| shares and compare values
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// one item per cycle while in_stall is low; the 16-stage share divider
// produces one quotient bit per stage
// the pipeline moves as a whole; a two-entry output buffer takes the result
// when out_stall is high, and in_stall rises only once that buffer is full
// rst_n is synchronous: clears all valid bits and loads register defaults
// cfg_ready is always high
// ----------------------------------------------------------------------------
module tunable_white_dim_to_pwm_compare
  import twd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DW-1:0]        in_mireds,
  input  logic [DW-1:0]        in_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DW-1:0]        out_cool_share,
  output logic [DW-1:0]        out_warm_share,
  output logic [DW-1:0]        out_cool_compare,
  output logic [DW-1:0]        out_warm_compare,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_wdata
);

  // configuration
  logic [DW-1:0] min_mireds_r;
  logic [DW-1:0] max_mireds_r;
  logic [DW-1:0] period_r;
  logic          active_low_r;

  // flow control
  logic             en;
  logic [NPIPE-1:0] valid_r;
  logic [NPIPE-1:0] vin;
  logic [NPIPE-1:0] ld;
  logic             pipe_out_v;

  // clamp stage
  logic [DW-1:0] mir_c;
  logic [DW-1:0] pos0_nxt, span0_nxt;
  logic          ok0_nxt;
  logic [DW-1:0] pos0_r, span0_r, level0_r;
  logic          ok0_r;

  // numerator stage
  logic [X_W-1:0] num1_nxt;
  logic [X_W-1:0] num1_r;
  logic [DW-1:0]  span1_r, level1_r;
  logic           ok1_r;

  // divider stages
  logic [DW-1:0] drem_nxt  [DW];
  logic [DW-1:0] dq_nxt    [DW];
  logic [DW-1:0] drem_r    [DW];
  logic [DW-1:0] dlo_r     [DW];
  logic [DW-1:0] dq_r      [DW];
  logic [DW-1:0] dspan_r   [DW];
  logic [DW-1:0] dlevel_r  [DW];
  logic          dok_r     [DW];

  // split stage
  logic [DW-1:0] warm_nxt, cool_nxt;
  logic [DW-1:0] share_r [NCH];
  side_t         side_nxt;
  side_t         side_r [STG_SPLIT:STG_TREM];

  // per-channel stages
  logic [NUM_W-1:0]   cnum_r   [NCH];
  logic [CPROD_W-1:0] cprod_r  [NCH];
  logic [NUM_W-1:0]   cnum_m_r [NCH];
  logic [NUM_W-1:0]   cqe_r    [NCH];
  logic [CREM_W-1:0]  crem_r   [NCH];
  logic [NUM_W-1:0]   curve_r  [NCH];
  logic [NUM_W-1:0]   tail_r   [NCH];
  logic [DW-1:0]      v_r      [NCH];
  logic [X_W-1:0]     x_r      [NCH];
  logic [TPROD_W-1:0] tprod_r  [NCH];
  logic [X_W-1:0]     x_m_r    [NCH];
  logic [DW-1:0]      tqe_r    [NCH];
  logic [TREM_W-1:0]  trem_r   [NCH];
  logic [DW-1:0]      tick_nxt [NCH];

  // output buffer
  res_t res_nxt;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mireds_r <= DW'(153);
      max_mireds_r <= DW'(370);
      period_r     <= DW'(65535);
      active_low_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_MIREDS:       min_mireds_r <= cfg_wdata;
        CFG_MAX_MIREDS:       max_mireds_r <= cfg_wdata;
        CFG_PWM_PERIOD_TICKS: period_r     <= cfg_wdata;
        CFG_ACTIVE_LOW:       active_low_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline advance: whole pipe moves unless the output buffer is full
  // --------------------------------------------------------------------------
  assign en         = !skid_valid_r;
  assign in_stall   = skid_valid_r;
  assign vin        = {valid_r[NPIPE-2:0], in_valid};
  assign ld         = vin & {NPIPE{en}};
  assign pipe_out_v = en && valid_r[NPIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= vin;
    end
  end

  // --------------------------------------------------------------------------
  // clamp mireds into the range, position and span
  // --------------------------------------------------------------------------
  always_comb begin
    mir_c = in_mireds;
    if (in_mireds < min_mireds_r) mir_c = min_mireds_r;
    if (in_mireds > max_mireds_r) mir_c = max_mireds_r;
    ok0_nxt   = (max_mireds_r > min_mireds_r);
    span0_nxt = max_mireds_r - min_mireds_r;
    pos0_nxt  = ok0_nxt ? (mir_c - min_mireds_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (ld[STG_CLAMP]) begin
      pos0_r   <= pos0_nxt;
      span0_r  <= span0_nxt;
      ok0_r    <= ok0_nxt;
      level0_r <= in_level;
    end
  end

  // position times level
  assign num1_nxt = X_W'(pos0_r) * X_W'(level0_r);

  always_ff @(posedge clk) begin
    if (ld[STG_MUL]) begin
      num1_r   <= num1_nxt;
      span1_r  <= span0_r;
      ok1_r    <= ok0_r;
      level1_r <= level0_r;
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage, msb first
  // numerator < span << DW, so the upper half already sits below the span
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DW-1:0] rem_in, lo_in, q_in, span_in, lvl_in;
    logic          ok_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = num1_r[X_W-1:DW];
      assign lo_in   = num1_r[DW-1:0];
      assign q_in    = '0;
      assign span_in = span1_r;
      assign lvl_in  = level1_r;
      assign ok_in   = ok1_r;
    end else begin : g_next
      assign rem_in  = drem_r[k-1];
      assign lo_in   = dlo_r[k-1];
      assign q_in    = dq_r[k-1];
      assign span_in = dspan_r[k-1];
      assign lvl_in  = dlevel_r[k-1];
      assign ok_in   = dok_r[k-1];
    end

    assign trial = {rem_in, lo_in[DW-1-k]};
    assign ge    = (trial >= {1'b0, span_in});

    always_comb begin
      drem_nxt[k] = ge ? DW'(trial - {1'b0, span_in}) : trial[DW-1:0];
      dq_nxt[k]   = q_in;
      dq_nxt[k][DW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (ld[STG_DIV0+k]) begin
        drem_r[k]   <= drem_nxt[k];
        dlo_r[k]    <= lo_in;
        dq_r[k]     <= dq_nxt[k];
        dspan_r[k]  <= span_in;
        dlevel_r[k] <= lvl_in;
        dok_r[k]    <= ok_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // split level into warm and cool shares
  // --------------------------------------------------------------------------
  always_comb begin
    warm_nxt            = dok_r[DW-1] ? dq_r[DW-1] : '0;
    cool_nxt            = dlevel_r[DW-1] - warm_nxt;
    side_nxt.cool_share = cool_nxt;
    side_nxt.warm_share = warm_nxt;
    side_nxt.tail_en    = (dlevel_r[DW-1][DW-1:TAIL_W] == '0);
    side_nxt.tail_mul   = dlevel_r[DW-1][TAIL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[STG_SPLIT]) begin
      share_r[CH_COOL]  <= cool_nxt;
      share_r[CH_WARM]  <= warm_nxt;
      side_r[STG_SPLIT] <= side_nxt;
    end
  end

  for (genvar s = STG_CNUM; s <= STG_TREM; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[s]) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // per-channel curve, tail scale, inversion and period scale
  // --------------------------------------------------------------------------
  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    logic [DW-1:0]      sh_c;
    logic [NUM_W-1:0]   kv;
    logic [NUM_W-1:0]   cnum_nxt;
    logic [CPROD_W-1:0] cprod_nxt;
    logic [NUM_W-1:0]   cqe_nxt;
    logic [CREM_W-1:0]  crem_nxt;
    logic [NUM_W-1:0]   curve_nxt;
    logic [TAILP_W-1:0] tprod_t;
    logic [NUM_W-1:0]   tail_nxt;
    logic [DW-1:0]      v_nxt;
    logic [X_W-1:0]     x_nxt;
    logic [TPROD_W-1:0] tprod_nxt;
    logic [DW-1:0]      tqe_nxt;
    logic [TREM_W-1:0]  trem_nxt;

    // floor + slope * v over top; zero stays zero
    always_comb begin
      sh_c = (share_r[ch] > DW'(FULL_SCALE)) ? DW'(FULL_SCALE) : share_r[ch];
      kv   = NUM_W'(CURVE_K) * NUM_W'(sh_c);
      if (CURVE_UP) begin
        cnum_nxt = NUM_W'(CURVE_BASE) + kv;
      end else begin
        cnum_nxt = NUM_W'(CURVE_BASE) - kv;
      end
      if (share_r[ch] == '0) cnum_nxt = '0;
    end

    assign cprod_nxt = CPROD_W'(cnum_r[ch]) * CPROD_W'(CURVE_RECIP);
    assign cqe_nxt   = NUM_W'(cprod_r[ch] >> NUM_W);
    assign crem_nxt  = CREM_W'(cnum_m_r[ch] - cqe_nxt * NUM_W'(TOP_PCT));
    // estimate is at most one low
    assign curve_nxt = cqe_r[ch] + NUM_W'(crem_r[ch] >= CREM_W'(TOP_PCT));

    assign tprod_t  = TAILP_W'(curve_r[ch]) * TAILP_W'(side_r[STG_CFIX].tail_mul);
    assign tail_nxt = side_r[STG_CFIX].tail_en ? NUM_W'(tprod_t >> TAIL_W) : curve_r[ch];

    always_comb begin
      v_nxt = (tail_r[ch] > NUM_W'(FULL_SCALE)) ? DW'(FULL_SCALE) : DW'(tail_r[ch]);
      if (active_low_r) v_nxt = DW'(FULL_SCALE) - v_nxt;
    end

    assign x_nxt     = X_W'(v_r[ch]) * X_W'(period_r);
    assign tprod_nxt = TPROD_W'(x_r[ch]) * TPROD_W'(TICK_RECIP);
    assign tqe_nxt   = DW'(tprod_r[ch] >> X_W);
    assign trem_nxt  = TREM_W'(x_m_r[ch] - X_W'(tqe_nxt) * X_W'(FULL_SCALE));
    assign tick_nxt[ch] = tqe_r[ch] + DW'(trem_r[ch] >= TREM_W'(FULL_SCALE));

    always_ff @(posedge clk) begin
      if (ld[STG_CNUM]) cnum_r[ch] <= cnum_nxt;
      if (ld[STG_CMUL]) begin
        cprod_r[ch]  <= cprod_nxt;
        cnum_m_r[ch] <= cnum_r[ch];
      end
      if (ld[STG_CREM]) begin
        cqe_r[ch]  <= cqe_nxt;
        crem_r[ch] <= crem_nxt;
      end
      if (ld[STG_CFIX]) curve_r[ch] <= curve_nxt;
      if (ld[STG_TAIL]) tail_r[ch]  <= tail_nxt;
      if (ld[STG_INV])  v_r[ch]     <= v_nxt;
      if (ld[STG_XMUL]) x_r[ch]     <= x_nxt;
      if (ld[STG_TMUL]) begin
        tprod_r[ch] <= tprod_nxt;
        x_m_r[ch]   <= x_r[ch];
      end
      if (ld[STG_TREM]) begin
        tqe_r[ch]  <= tqe_nxt;
        trem_r[ch] <= trem_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid entry
  // --------------------------------------------------------------------------
  always_comb begin
    res_nxt.cool_share   = side_r[STG_TREM].cool_share;
    res_nxt.warm_share   = side_r[STG_TREM].warm_share;
    res_nxt.cool_compare = tick_nxt[CH_COOL];
    res_nxt.warm_compare = tick_nxt[CH_WARM];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pipe_out_v;
      end
    end else if (pipe_out_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (pipe_out_v) begin
        out_r <= res_nxt;
      end
    end else if (pipe_out_v) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cool_share   = out_r.cool_share;
  assign out_warm_share   = out_r.warm_share;
  assign out_cool_compare = out_r.cool_compare;
  assign out_warm_compare = out_r.warm_compare;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // skid entry is only used behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a transfer while the output register is empty");

  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled without a stalled output");

  // divider remainder stays below the span on every valid split
  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[STG_SPLIT-1] && dok_r[DW-1]) |-> (drem_r[DW-1] < dspan_r[DW-1]))
    else $error("divider remainder not below span");

endmodule

/* sim/twd_dim_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twd_dim_checker
// Watches the input, result and register-write channels of the tunable-white
// dimming block, predicts the shares and PWM compare values of every input
// transfer from its own copy of the registers, and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module twd_dim_checker
  import twd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [DW-1:0]        in_mireds,
  input  logic [DW-1:0]        in_level,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [DW-1:0]        out_cool_share,
  input  logic [DW-1:0]        out_warm_share,
  input  logic [DW-1:0]        out_cool_compare,
  input  logic [DW-1:0]        out_warm_compare,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_wdata,
  output int                   errors,
  output int                   pending
);

  logic [DW-1:0] min_mireds_q;
  logic [DW-1:0] max_mireds_q;
  logic [DW-1:0] period_q;
  logic          active_low_q;

  res_t dim_results_q[$];

  // curve with floor, tail scale, inversion and period scaling of one share
  function automatic logic [DW-1:0] channel_ticks(logic [DW-1:0] share,
                                                  logic [DW-1:0] lvl);
    longint unsigned v;
    v = longint'(share);
    if (v != 0) begin
      if (v > longint'(FULL_SCALE)) v = longint'(FULL_SCALE);
      v = (longint'(FLOOR_PCT) * longint'(FULL_SCALE)
           + longint'(TOP_PCT - FLOOR_PCT) * v) / longint'(TOP_PCT);
    end
    if (lvl < 16'd256) v = (v * longint'(lvl)) / 256;
    if (v > longint'(FULL_SCALE)) v = longint'(FULL_SCALE);
    if (active_low_q) v = longint'(FULL_SCALE) - v;
    v = (v * longint'(period_q)) / longint'(FULL_SCALE);
    return v[DW-1:0];
  endfunction

  function automatic res_t predict_dimming(logic [DW-1:0] mir, logic [DW-1:0] lvl);
    res_t            r;
    longint unsigned m;
    longint unsigned w;
    longint unsigned span;
    m = longint'(mir);
    w = 0;
    // reversed or empty range leaves the whole level on the cool side
    if (max_mireds_q > min_mireds_q) begin
      span = longint'(max_mireds_q) - longint'(min_mireds_q);
      if (m < longint'(min_mireds_q)) m = longint'(min_mireds_q);
      if (m > longint'(max_mireds_q)) m = longint'(max_mireds_q);
      w = ((m - longint'(min_mireds_q)) * longint'(lvl)) / span;
    end
    r.warm_share   = w[DW-1:0];
    r.cool_share   = lvl - r.warm_share;
    r.cool_compare = channel_ticks(r.cool_share, lvl);
    r.warm_compare = channel_ticks(r.warm_share, lvl);
    return r;
  endfunction

  task automatic check_field(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      min_mireds_q = 16'd153;
      max_mireds_q = 16'd370;
      period_q     = 16'd65535;
      active_low_q = 1'b0;
      dim_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_MIREDS:       min_mireds_q = cfg_wdata;
          CFG_MAX_MIREDS:       max_mireds_q = cfg_wdata;
          CFG_PWM_PERIOD_TICKS: period_q     = cfg_wdata;
          CFG_ACTIVE_LOW:       active_low_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (dim_results_q.size() == 0) begin
          $display("%0t: result transfer with none expected, got %0d %0d %0d %0d", $time,
                   out_cool_share, out_warm_share, out_cool_compare, out_warm_compare);
          errors++;
        end else begin
          exp_r = dim_results_q.pop_front();
          check_field("cool_share", exp_r.cool_share, out_cool_share);
          check_field("warm_share", exp_r.warm_share, out_warm_share);
          check_field("cool_compare", exp_r.cool_compare, out_cool_compare);
          check_field("warm_compare", exp_r.warm_compare, out_warm_compare);
        end
      end
      if (in_valid && !in_stall) dim_results_q.push_back(predict_dimming(in_mireds, in_level));
    end
    pending <= dim_results_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tunable-white dimming block: directed corner items, then
// phases of random items under different register settings and idle/stall
// mixes, including one long result hold-off. Checking is in twd_dim_checker.
// ----------------------------------------------------------------------------
module tb;
  import twd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 112;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hA5;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [DW-1:0]        in_mireds;
  logic [DW-1:0]        in_level;
  logic                 out_valid;
  logic                 out_stall;
  logic [DW-1:0]        out_cool_share;
  logic [DW-1:0]        out_warm_share;
  logic [DW-1:0]        out_cool_compare;
  logic [DW-1:0]        out_warm_compare;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]        cfg_wdata;

  int errors;
  int pending;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int cycle_count;

  always #2 clk = ~clk;

  tunable_white_dim_to_pwm_compare dut (.*);

  twd_dim_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    int hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_req;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // leaves in_valid high after the transfer; the next call lowers it if idle
  task automatic send_dim_cmd(logic [DW-1:0] mir, logic [DW-1:0] lvl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mireds <= mir;
    in_level  <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    int unsigned cmin, cmax, period, al;
    int unsigned lo, hi, r;
    logic [DW-1:0] mir, lvl;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mireds   <= '0;
    in_level    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MIN_MIREDS;
    cfg_wdata   <= '0;
    idle_pct    <= 0;
    stall_pct   <= 0;
    hold_req    <= 0;
    cycle_count <= 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under the reset register values (153..370 mireds)
    send_dim_cmd(16'd0, 16'd0);
    send_dim_cmd(16'd0, 16'd65280);
    send_dim_cmd(16'd153, 16'd65280);
    send_dim_cmd(16'd370, 16'd65280);
    send_dim_cmd(16'd65535, 16'd65280);
    send_dim_cmd(16'd261, 16'd65280);
    send_dim_cmd(16'd261, 16'd65535);
    send_dim_cmd(16'd370, 16'd65535);
    send_dim_cmd(16'd153, 16'd65535);
    send_dim_cmd(16'd261, 16'd256);
    send_dim_cmd(16'd261, 16'd255);
    send_dim_cmd(16'd200, 16'd128);
    send_dim_cmd(16'd370, 16'd1);
    send_dim_cmd(16'd153, 16'd1);
    send_dim_cmd(16'd152, 16'd0);
    send_dim_cmd(16'd371, 16'd32768);
    send_dim_cmd(16'hAAAA, 16'h5555);
    send_dim_cmd(16'h5555, 16'hAAAA);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin cmin = 153;   cmax = 370;   period = 65535; al = 0; end
        1: begin cmin = 0;     cmax = 65535; period = 65535; al = 1; end
        2: begin cmin = 500;   cmax = 500;   period = 1000;  al = 0; end
        3: begin cmin = 600;   cmax = 200;   period = 255;   al = 1; end
        4: begin cmin = 0;     cmax = 0;     period = 0;     al = 0; end
        5: begin cmin = 65535; cmax = 65535; period = 65535; al = 1; end
        6: begin cmin = 0;     cmax = 1;     period = 1;     al = 0; end
        default: begin
          cmin   = $urandom_range(1000);
          cmax   = cmin + $urandom_range(2000);
          period = $urandom_range(65535);
          al     = $urandom_range(1);
        end
      endcase
      // a write to an unused index must change nothing
      write_reg(CFG_UNUSED_IDX, DW'($urandom));
      write_reg(CFG_MIN_MIREDS, DW'(cmin));
      write_reg(CFG_MAX_MIREDS, DW'(cmax));
      write_reg(CFG_PWM_PERIOD_TICKS, DW'(period));
      write_reg(CFG_ACTIVE_LOW, DW'(al));
      cfg_valid <= 1'b0;
      @(posedge clk);

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 84; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 84; end
        default: begin idle_pct = 28; stall_pct <= 28; end
      endcase

      // endpoints at full level: one channel off, inverted when active low
      send_dim_cmd(DW'(cmin), 16'd65280);
      send_dim_cmd(DW'(cmax), 16'd65280);
      send_dim_cmd(16'd0, 16'd0);
      send_dim_cmd(16'd65535, 16'd255);

      lo = (cmin < cmax) ? cmin : cmax;
      hi = (cmin < cmax) ? cmax : cmin;
      lo = (lo > 20) ? lo - 20 : 0;
      hi = (hi < 65515) ? hi + 20 : 65535;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 4 && i == 10) hold_req <= hold_req + 1;
        if ($urandom_range(9) < 2) mir = DW'($urandom);
        else                       mir = DW'($urandom_range(hi, lo));
        r = $urandom_range(9);
        if (r < 2)       lvl = DW'($urandom_range(255));
        else if (r == 2) lvl = DW'($urandom_range(65535, 65280));
        else             lvl = DW'($urandom);
        send_dim_cmd(mir, lvl);
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/twd_pkg.sv
src/tunable_white_dim_to_pwm_compare.sv
sim/twd_dim_checker.sv
sim/tb.sv
